// ----- rtl/srbe_pkg.sv -----
package srbe_pkg;

    localparam int FUNC_W      = 3;
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 11;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    localparam logic [FUNC_W-1:0] FUNC_RX_BYTE  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ     = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PUT_BACK = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SEND     = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_TX_READY = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;

    typedef struct packed {
        logic push;
        logic rd;
        logic back;
        logic clear;
        logic take;
    } ring_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ring_sts_t;

endpackage

// ----- rtl/serial_ring_buffer_engine_core.sv -----
// Receive and transmit byte rings between a serial line and software.
// Input items arrive on the s_axis channel: tuser holds the function code
// (byte received, read, put back, clear, send, transmit ready) and tdata the
// byte. Results leave on the m_axis channel; tlast marks the final result of
// an input item, tuser is set when the byte goes to the transmitter, and
// tdata carries the byte, both ring counts, the interrupt enable and status.
// Every item gives one result, except a transmit-ready event on a non-empty
// ring, which gives one result per byte sent, up to BURST_MAX when fifo_mode
// is set and one otherwise.
// The result of an item enters the output register from the state that the
// item selects, once that register is free; a read or a burst reads the
// ring memory in the cycle in which the item is accepted. A burst then emits
// one byte per cycle while the output register is free. The next item is
// accepted in the cycle after the previous item's last result has entered
// the output register. When the receiver stalls, the output register holds
// its item and the block waits; it may still accept one new item meanwhile.
// Reset empties both rings, clears the interrupt enable and fifo_mode.
// The ring memories need no clearing pass.
module serial_ring_buffer_engine_core #(
    parameter int RING_DEPTH = 2048,
    parameter int BURST_MAX  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_wr_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: data_in.
    input  logic [srbe_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // Fields from bit 0: func.
    input  logic [srbe_pkg::FUNC_W-1:0]          s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0: data_out, rx_count, tx_count, tx_irq_on, status.
    output logic [srbe_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // Fields from bit 0: to_line.
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast
);
    import srbe_pkg::*;

    localparam int PTR_W   = $clog2(RING_DEPTH);
    localparam int BURST_W = $clog2(BURST_MAX + 1);
    localparam int CMP_W   = (PTR_W > BURST_W) ? PTR_W : BURST_W;
    localparam int PAD_W   = OUT_TDATA_W - (BYTE_W + 2 * CNT_W + 1 + STATUS_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESULT,
        ST_RX_DATA,
        ST_TX_DATA
    } state_t;

    state_t               state_reg;
    logic [BURST_W-1:0]   burst_left_reg;
    logic [STATUS_W-1:0]  res_status_reg;
    logic                 fifo_mode_reg;
    logic                 tx_irq_reg;
    logic                 m_valid_reg;
    logic [BYTE_W-1:0]    m_data_reg;
    logic                 m_line_reg;
    logic                 m_last_reg;
    logic [CNT_W-1:0]     m_rxcnt_reg;
    logic [CNT_W-1:0]     m_txcnt_reg;
    logic                 m_irq_reg;
    logic [STATUS_W-1:0]  m_status_reg;

    ring_ctl_t            rx_ctl;
    ring_ctl_t            tx_ctl;
    ring_sts_t            rx_sts;
    ring_sts_t            tx_sts;
    logic [BYTE_W-1:0]    rx_rdata;
    logic [BYTE_W-1:0]    tx_rdata;
    logic [PTR_W-1:0]     rx_count;
    logic [PTR_W-1:0]     tx_count;
    logic [PTR_W-1:0]     tx_take_n;
    logic [BURST_W-1:0]   burst_n;
    logic [CMP_W-1:0]     burst_limit;
    logic [CMP_W-1:0]     burst_cmp;
    logic                 accept;
    logic                 out_free;
    logic [FUNC_W-1:0]    func;
    logic [BYTE_W-1:0]    data_in;

    assign func          = s_axis_tuser;
    assign data_in       = s_axis_tdata[BYTE_W-1:0];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign burst_limit = fifo_mode_reg ? CMP_W'(BURST_MAX) : CMP_W'(1);
    assign burst_cmp   = (CMP_W'(tx_count) < burst_limit) ? CMP_W'(tx_count) : burst_limit;
    assign tx_take_n   = PTR_W'(burst_cmp);
    assign burst_n     = BURST_W'(burst_cmp);

    always_comb
    begin
        rx_ctl = '0;
        tx_ctl = '0;
        if (accept)
        begin
            case (func)
                FUNC_RX_BYTE:  rx_ctl.push = !rx_sts.full;
                FUNC_READ:
                begin
                    rx_ctl.rd   = !rx_sts.empty;
                    rx_ctl.take = !rx_sts.empty;
                end
                FUNC_PUT_BACK: rx_ctl.back = !rx_sts.full;
                FUNC_CLEAR:    rx_ctl.clear = 1'b1;
                FUNC_SEND:     tx_ctl.push = !tx_sts.full;
                FUNC_TX_READY:
                begin
                    tx_ctl.rd   = !tx_sts.empty;
                    tx_ctl.take = !tx_sts.empty;
                end
                default:
                begin
                    rx_ctl = '0;
                    tx_ctl = '0;
                end
            endcase
        end
        else if (state_reg == ST_TX_DATA && out_free && burst_left_reg > BURST_W'(1))
        begin
            tx_ctl.rd = 1'b1;
        end
    end

    srbe_ring #(
        .DEPTH (RING_DEPTH)
    ) u_rx_ring (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (rx_ctl),
        .wdata  (data_in),
        .take_n (PTR_W'(1)),
        .rdata  (rx_rdata),
        .count  (rx_count),
        .sts    (rx_sts)
    );

    srbe_ring #(
        .DEPTH (RING_DEPTH)
    ) u_tx_ring (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (tx_ctl),
        .wdata  (data_in),
        .take_n (tx_take_n),
        .rdata  (tx_rdata),
        .count  (tx_count),
        .sts    (tx_sts)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            burst_left_reg <= '0;
            res_status_reg <= STATUS_OK;
            fifo_mode_reg  <= 1'b0;
            tx_irq_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
            m_line_reg     <= 1'b0;
            m_last_reg     <= 1'b0;
            m_rxcnt_reg    <= '0;
            m_txcnt_reg    <= '0;
            m_irq_reg      <= 1'b0;
            m_status_reg   <= STATUS_OK;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                fifo_mode_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        res_status_reg <= STATUS_OK;
                        state_reg      <= ST_RESULT;
                        case (func)
                            FUNC_RX_BYTE:
                            begin
                                if (rx_sts.full)
                                begin
                                    res_status_reg <= STATUS_DROPPED;
                                end
                            end
                            FUNC_READ:
                            begin
                                if (rx_sts.empty)
                                begin
                                    res_status_reg <= STATUS_EMPTY;
                                end
                                else
                                begin
                                    state_reg <= ST_RX_DATA;
                                end
                            end
                            FUNC_SEND:
                            begin
                                tx_irq_reg <= 1'b1;
                                if (tx_sts.full)
                                begin
                                    res_status_reg <= STATUS_DROPPED;
                                end
                            end
                            FUNC_TX_READY:
                            begin
                                if (tx_sts.empty)
                                begin
                                    tx_irq_reg <= 1'b0;
                                end
                                else
                                begin
                                    burst_left_reg <= burst_n;
                                    state_reg      <= ST_TX_DATA;
                                end
                            end
                            default:
                            begin
                                res_status_reg <= STATUS_OK;
                            end
                        endcase
                    end
                end
                ST_RESULT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_data_reg   <= '0;
                        m_line_reg   <= 1'b0;
                        m_last_reg   <= 1'b1;
                        m_rxcnt_reg  <= CNT_W'(rx_count);
                        m_txcnt_reg  <= CNT_W'(tx_count);
                        m_irq_reg    <= tx_irq_reg;
                        m_status_reg <= res_status_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_RX_DATA:
                begin
                    if (out_free)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_data_reg   <= rx_rdata;
                        m_line_reg   <= 1'b0;
                        m_last_reg   <= 1'b1;
                        m_rxcnt_reg  <= CNT_W'(rx_count);
                        m_txcnt_reg  <= CNT_W'(tx_count);
                        m_irq_reg    <= tx_irq_reg;
                        m_status_reg <= STATUS_OK;
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_TX_DATA:
                begin
                    if (out_free)
                    begin
                        m_valid_reg    <= 1'b1;
                        m_data_reg     <= tx_rdata;
                        m_line_reg     <= 1'b1;
                        m_last_reg     <= (burst_left_reg == BURST_W'(1));
                        m_rxcnt_reg    <= CNT_W'(rx_count);
                        m_txcnt_reg    <= CNT_W'(tx_count);
                        m_irq_reg      <= tx_irq_reg;
                        m_status_reg   <= STATUS_OK;
                        burst_left_reg <= burst_left_reg - 1'b1;
                        if (burst_left_reg == BURST_W'(1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_line_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, m_status_reg, m_irq_reg,
                            m_txcnt_reg, m_rxcnt_reg, m_data_reg};

    // A burst in progress always has at least one byte left to emit.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TX_DATA |-> burst_left_reg != '0)
    else $error("burst state entered with no bytes left");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && func == FUNC_READ && !rx_sts.empty |=> state_reg == ST_RX_DATA)
    else $error("read of a non-empty ring did not wait for memory data");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TX_DATA && out_free && burst_left_reg == BURST_W'(1)
        |=> state_reg == ST_IDLE && m_axis_tlast && m_axis_tuser)
    else $error("final burst byte not marked or burst did not end");

    assert property (@(posedge clk) disable iff (!rst_n)
        rx_count <= PTR_W'(RING_DEPTH - 1) && tx_count <= PTR_W'(RING_DEPTH - 1))
    else $error("ring count beyond capacity");

    // The burst reads the ring only while a byte is waiting in it.
    assert property (@(posedge clk) disable iff (!rst_n)
        tx_ctl.rd && tx_ctl.take |-> tx_take_n != '0)
    else $error("burst started with zero length");

endmodule

// ----- rtl/srbe_ring.sv -----
module srbe_ring #(
    parameter int DEPTH = 2048
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  srbe_pkg::ring_ctl_t           ctl,
    input  logic [srbe_pkg::BYTE_W-1:0]   wdata,
    input  logic [$clog2(DEPTH)-1:0]      take_n,
    output logic [srbe_pkg::BYTE_W-1:0]   rdata,
    output logic [$clog2(DEPTH)-1:0]      count,
    output srbe_pkg::ring_sts_t           sts
);
    import srbe_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [PTR_W-1:0]  count_reg;
    logic [PTR_W-1:0]  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (ctl.clear)
        begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            count_next  = '0;
        end
        else
        begin
            if (ctl.push)
            begin
                wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
                count_next  = count_reg + 1'b1;
            end
            if (ctl.back)
            begin
                rd_ptr_next = (rd_ptr_reg == '0) ? LAST_PTR : rd_ptr_reg - 1'b1;
                count_next  = count_reg + 1'b1;
            end
            if (ctl.rd)
            begin
                rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (ctl.take)
            begin
                count_next = count_reg - take_n;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
        if (ctl.rd)
        begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

    assign rdata     = rdata_reg;
    assign count     = count_reg;
    assign sts.full  = (count_reg == LAST_PTR);
    assign sts.empty = (count_reg == '0);

endmodule
